@@ sv/ftrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ftrc_pkg: shared types and constants for the refresh-counted forwarding table
// Holds the request codes, the field widths and the packet that walks the
// row of table cells.
// ----------------------------------------------------------------------------
package ftrc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned CountW = 8;
  localparam int unsigned UsedW  = 6;
  localparam int unsigned ReqW   = 2;

  // Result fields: hit, count_after, removed, table_full_drop, entries_used.
  localparam int unsigned OutFieldsW = 1 + CountW + 1 + 1 + UsedW;
  localparam int unsigned OutW       = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [CountW-1:0] LimitReset = 8'd3;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT    = 2'd0,
    REQ_DELETE    = 2'd1,
    REQ_DECREMENT = 2'd2,
    REQ_QUERY     = 2'd3
  } ftrc_req_t;

  // Packet handed from cell to cell. The lookup pass gathers hit, count and
  // occupancy; the claim pass places a new key in the first free cell.
  typedef struct packed {
    logic              vld;
    logic              claim;
    ftrc_req_t         op;
    logic [KeyW-1:0]   key;
    logic              hit;
    logic [CountW-1:0] cnt;
    logic              removed;
    logic              free_seen;
    logic              taken;
    logic [UsedW-1:0]  used;
  } ftrc_pkt_t;

endpackage

@@ sv/ftrc_cell.sv @@
// ----------------------------------------------------------------------------
// ftrc_cell: one table entry of the forwarding table
// Holds a valid bit, a key and a refresh count, applies the passing request
// to itself on a key match and registers the packet for the next cell.
// ----------------------------------------------------------------------------
module ftrc_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ftrc_pkg::CountW-1:0]   limit,
  input  ftrc_pkg::ftrc_pkt_t           pkt_in,
  output ftrc_pkg::ftrc_pkt_t           pkt_out
);
  import ftrc_pkg::*;

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CountW-1:0]   count_r, count_nxt;
  ftrc_pkt_t           pkt_r, pkt_nxt;
  logic                match;

  assign match = valid_r && (key_r == pkt_in.key[KEY_BITS-1:0]);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    pkt_nxt   = pkt_in;
    if (pkt_in.vld) begin
      if (pkt_in.claim) begin
        if (!pkt_in.taken && !valid_r) begin
          valid_nxt     = 1'b1;
          key_nxt       = pkt_in.key[KEY_BITS-1:0];
          count_nxt     = limit;
          pkt_nxt.taken = 1'b1;
        end
      end else begin
        if (match) begin
          pkt_nxt.hit = 1'b1;
          unique case (pkt_in.op)
            REQ_INSERT: begin
              // A count left above a lowered limit is kept as it is.
              if (count_r < limit) begin
                count_nxt = count_r + CountW'(1);
              end
              pkt_nxt.cnt = count_nxt;
            end
            REQ_DELETE: begin
              valid_nxt       = 1'b0;
              pkt_nxt.removed = 1'b1;
            end
            REQ_DECREMENT: begin
              if (count_r <= CountW'(1)) begin
                valid_nxt       = 1'b0;
                pkt_nxt.removed = 1'b1;
              end else begin
                count_nxt   = count_r - CountW'(1);
                pkt_nxt.cnt = count_nxt;
              end
            end
            REQ_QUERY: begin
              pkt_nxt.cnt = count_r;
            end
          endcase
        end
        if (!valid_r) begin
          pkt_nxt.free_seen = 1'b1;
        end
        pkt_nxt.used = pkt_in.used + UsedW'(valid_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pkt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pkt_r   <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
  end

  assign pkt_out = pkt_r;

endmodule

@@ sv/forwarding_table_refresh_counts.sv @@
// ----------------------------------------------------------------------------
// forwarding_table_refresh_counts: associative key table with refresh counts
// Top level: request channel, result channel, refresh limit register and the
// row of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per item: group_key on in_tdata and
//   the operation on in_tuser. The result channel returns one item per request.
//   cfg_wr_en/cfg_wr_data load the refresh limit; write it only while idle.
//   Each request walks the row of TABLE_ENTRIES cells, one cell per cycle.
//   The result is registered once the walk leaves the last cell; an insert
//   of a new key with a free slot makes a second walk to claim the lowest
//   free cell. The next request is taken only after the result has moved
//   into the output register, so the block does not take a new request
//   while one is still walking the cells.
//   One result register sits at the output: while the receiver stalls the
//   block still accepts and processes the next request and holds its result
//   until the output register frees up.
//   Reset empties the table and sets the refresh limit to 3.
// ----------------------------------------------------------------------------
module forwarding_table_refresh_counts #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned KEY_BITS      = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ftrc_pkg::KeyW-1:0]     in_tdata,    // [63:0] group_key
  input  logic [ftrc_pkg::ReqW-1:0]     in_tuser,    // [1:0] req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] hit, [8:1] count_after, [9] removed, [10] table_full_drop,
  // [16:11] entries_used, [23:17] zero
  output logic [ftrc_pkg::OutW-1:0]     out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [ftrc_pkg::CountW-1:0]   cfg_wr_data
);
  import ftrc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CountW-1:0] limit_r, limit_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic [CountW-1:0] res_cnt_r, res_cnt_nxt;
  logic              res_removed_r, res_removed_nxt;
  logic              res_drop_r, res_drop_nxt;
  logic [UsedW-1:0]  res_used_r, res_used_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OutW-1:0]   out_data_r, out_data_nxt;
  logic              accept;
  ftrc_pkt_t         inject;
  ftrc_pkt_t         link [TABLE_ENTRIES+1];
  ftrc_pkt_t         link_end;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign link[0]   = inject;
  assign link_end  = link[TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ftrc_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .limit   (limit_r),
      .pkt_in  (link[i]),
      .pkt_out (link[i+1])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    limit_nxt       = cfg_wr_en ? cfg_wr_data : limit_r;
    res_hit_nxt     = res_hit_r;
    res_cnt_nxt     = res_cnt_r;
    res_removed_nxt = res_removed_r;
    res_drop_nxt    = res_drop_r;
    res_used_nxt    = res_used_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    inject          = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          inject.vld = 1'b1;
          inject.op  = ftrc_req_t'(in_tuser);
          inject.key = in_tdata;
          state_nxt  = ST_PASS1;
        end
      end
      ST_PASS1: begin
        if (link_end.vld) begin
          res_hit_nxt     = link_end.hit;
          res_cnt_nxt     = link_end.cnt;
          res_removed_nxt = link_end.removed;
          res_used_nxt    = link_end.used;
          res_drop_nxt    = 1'b0;
          state_nxt       = ST_DONE;
          if (link_end.op == REQ_INSERT && !link_end.hit) begin
            if (link_end.free_seen) begin
              // Key is absent: send a claim down the row for the first free cell.
              inject.vld   = 1'b1;
              inject.claim = 1'b1;
              inject.op    = link_end.op;
              inject.key   = link_end.key;
              state_nxt    = ST_PASS2;
            end else begin
              res_drop_nxt = 1'b1;
            end
          end
        end
      end
      ST_PASS2: begin
        if (link_end.vld) begin
          res_cnt_nxt  = limit_r;
          res_used_nxt = res_used_r + UsedW'(1);
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OutW - OutFieldsW)'(0), res_used_r, res_drop_r,
                           res_removed_r, res_cnt_r, res_hit_r};
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LimitReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_hit_r     <= res_hit_nxt;
    res_cnt_r     <= res_cnt_nxt;
    res_removed_r <= res_removed_nxt;
    res_drop_r    <= res_drop_nxt;
    res_used_r    <= res_used_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted request keeps the block busy for at least the next cycle.
  ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("request accepted while a walk was starting");

  // A packet leaves the row only while a walk is outstanding.
  ap_end_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    link_end.vld |-> (state_r == ST_PASS1 || state_r == ST_PASS2))
    else $error("packet left the cell row with no walk in progress");

  // A dropped insert reports a miss with no count and no removal.
  ap_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_drop_r) |->
      (!res_hit_r && !res_removed_r && res_cnt_r == '0))
    else $error("dropped insert carries hit, count or removal");

  // A removal only happens on a hit and leaves a zero count.
  ap_removed_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_removed_r) |-> (res_hit_r && res_cnt_r == '0))
    else $error("removal reported without a hit or with a count");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for the refresh-counted forwarding table
// Drives table requests on the input stream and checks every result item
// against a behavioral table kept inside the bench. It loads several refresh
// limits between phases and stalls both streams at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ftrc_pkg::*;

  localparam int unsigned Entries       = 32;
  localparam int unsigned RandomItems   = 625;
  localparam int unsigned PoolMax       = 96;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned LongHold      = 600;
  localparam longint unsigned TimeoutCycles = 1_000_000;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_LIMIT,
    STEP_DRAIN
  } step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    ftrc_req_t         op;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] limit;
    logic [15:0]       gap;
  } plan_step_t;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] count;
    logic              removed;
    logic              drop;
    logic [UsedW-1:0]  used;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [KeyW-1:0]     in_tdata = '0;    // [63:0] group_key
  logic [ReqW-1:0]     in_tuser = '0;    // [1:0] req_type
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutW-1:0]     out_tdata;        // hit, count_after, removed, drop, used
  logic                cfg_wr_en = 1'b0;
  logic [CountW-1:0]   cfg_wr_data = '0;

  // Behavioral copy of the table and its limit register.
  logic                tbl_valid [Entries];
  logic [KeyW-1:0]     tbl_key   [Entries];
  logic [CountW-1:0]   tbl_count [Entries];
  logic [CountW-1:0]   refresh_limit = LimitReset;

  plan_step_t          plan[$];
  table_result_t       expected_results[$];
  logic [KeyW-1:0]     key_pool[$];
  int unsigned         n_outstanding = 0;
  int unsigned         gap_left = 0;
  int unsigned         quiet_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned removals_seen = 0;
  int unsigned full_seen = 0;
  int unsigned limit_writes = 0;

  int unsigned rx_taken = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left = 0;
  logic        rx_steady = 1'b0;

  forwarding_table_refresh_counts #(
    .TABLE_ENTRIES(Entries),
    .KEY_BITS     (KeyW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < Entries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = '0;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sender_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return pause_len();
  endfunction

  // Applies one request to the behavioral table and returns its result item.
  function automatic table_result_t apply_request(ftrc_req_t op, logic [KeyW-1:0] key);
    table_result_t r;
    int            slot;
    int            free_slot;
    int unsigned   n;
    r         = '0;
    slot      = -1;
    free_slot = -1;
    n         = 0;
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && slot < 0) slot = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    r.hit = (slot >= 0);
    case (op)
      REQ_INSERT: begin
        if (slot >= 0) begin
          if (tbl_count[slot] < refresh_limit) tbl_count[slot] = tbl_count[slot] + CountW'(1);
          r.count = tbl_count[slot];
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot]   = key;
          tbl_count[free_slot] = refresh_limit;
          r.count              = refresh_limit;
        end else begin
          r.drop = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          r.removed       = 1'b1;
        end
      end
      REQ_DECREMENT: begin
        if (slot >= 0) begin
          if (tbl_count[slot] <= 1) begin
            tbl_valid[slot] = 1'b0;
            r.removed       = 1'b1;
          end else begin
            tbl_count[slot] = tbl_count[slot] - CountW'(1);
            r.count         = tbl_count[slot];
          end
        end
      end
      default: begin
        if (slot >= 0) r.count = tbl_count[slot];
      end
    endcase
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i]) n++;
    end
    r.used = n[UsedW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_request(ftrc_req_t op, logic [KeyW-1:0] key);
    plan_step_t s;
    s       = '0;
    s.kind  = STEP_REQ;
    s.op    = op;
    s.key   = key;
    s.gap   = 16'(sender_gap());
    plan.push_back(s);
  endtask

  task automatic push_control(step_kind_t kind, logic [CountW-1:0] limit);
    plan_step_t s;
    s       = '0;
    s.kind  = kind;
    s.limit = limit;
    plan.push_back(s);
  endtask

  // Draws a key: a known one, a fresh random one, or a one-bit neighbor of a
  // known one. Keys that can be inserted always stay in the pool, so that
  // later deletes and decrements can still reach every stored entry.
  function automatic logic [KeyW-1:0] pick_key(int unsigned fresh_pct, logic for_insert);
    logic [KeyW-1:0] k;
    int unsigned     b;
    if (key_pool.size() != 0 && $urandom_range(0, 99) >= fresh_pct)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (key_pool.size() != 0 && $urandom_range(0, 3) == 0) begin
      k    = key_pool[$urandom_range(0, key_pool.size() - 1)];
      b    = $urandom_range(0, KeyW - 1);
      k[b] = ~k[b];
    end else begin
      k = {$urandom, $urandom};
    end
    if (key_pool.size() < PoolMax) key_pool.push_back(k);
    else if (for_insert) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    return k;
  endfunction

  function automatic logic [CountW-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3:       return 8'd2;
      default: return CountW'($urandom_range(1, 254));
    endcase
  endfunction

  // Request driver: plays the plan one step per handshake.
  always @(posedge clk) begin
    logic              nxt_valid;
    logic              nxt_wr;
    logic              took;
    logic [KeyW-1:0]   nxt_key;
    logic [ReqW-1:0]   nxt_op;
    logic [CountW-1:0] nxt_limit;
    took      = in_tvalid && in_tready;
    nxt_valid = in_tvalid;
    nxt_key   = in_tdata;
    nxt_op    = in_tuser;
    nxt_wr    = 1'b0;
    nxt_limit = cfg_wr_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_tvalid || took) begin
      nxt_valid = 1'b0;
      if (!took && !cfg_wr_en && n_outstanding == 0) quiet_cycles++;
      else quiet_cycles = 0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (plan.size() != 0) begin
        if (plan[0].kind == STEP_REQ) begin
          nxt_valid = 1'b1;
          nxt_key   = plan[0].key;
          nxt_op    = plan[0].op;
          gap_left  = 32'(plan[0].gap);
          void'(plan.pop_front());
        end else if (quiet_cycles >= SettleCycles) begin
          // Limit writes and pauses wait until the table has gone quiet.
          nxt_wr       = (plan[0].kind == STEP_LIMIT);
          nxt_limit    = plan[0].limit;
          quiet_cycles = 0;
          void'(plan.pop_front());
        end
      end
    end
    in_tvalid   <= nxt_valid;
    in_tdata    <= nxt_key;
    in_tuser    <= nxt_op;
    cfg_wr_en   <= nxt_wr;
    cfg_wr_data <= nxt_limit;
  end

  // Result receiver: random stalls, steady stretches and two long hold-offs
  // that start while the sender is offering, so the block backs up.
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) rx_taken++;
      if (hold_left != 0) begin
        hold_left--;
      end else if (in_tvalid && ((holds_done == 0 && rx_taken >= 100) ||
                                 (holds_done == 1 && rx_taken >= 420))) begin
        hold_left = LongHold;
        holds_done++;
      end else if (stall_left != 0) begin
        stall_left--;
      end else begin
        rdy = 1'b1;
        if (!rx_steady && $urandom_range(0, 7) == 0) stall_left = pause_len();
      end
      if (mode_left == 0) begin
        rx_steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
    end
    out_tready <= rdy;
  end

  // Monitor: predicts on each accepted request, checks each accepted result.
  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n) begin
      if (cfg_wr_en) begin
        refresh_limit = cfg_wr_data;
        limit_writes++;
      end
      if (in_tvalid && in_tready) begin
        want = apply_request(ftrc_req_t'(in_tuser), in_tdata);
        expected_results.push_back(want);
        if (want.hit) hits_seen++;
        if (want.drop) drops_seen++;
        if (want.removed) removals_seen++;
        if (want.used == Entries) full_seen++;
      end
      if (out_tvalid && out_tready) begin
        got.hit     = out_tdata[0];
        got.count   = out_tdata[8:1];
        got.removed = out_tdata[9];
        got.drop    = out_tdata[10];
        got.used    = out_tdata[16:11];
        if (expected_results.size() == 0) begin
          $error("result item with no request outstanding: 0x%0h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(got.hit));
          check_field("count_after", 64'(want.count), 64'(got.count));
          check_field("removed", 64'(want.removed), 64'(got.removed));
          check_field("table_full_drop", 64'(want.drop), 64'(got.drop));
          check_field("entries_used", 64'(want.used), 64'(got.used));
          results_checked++;
        end
      end
    end
    n_outstanding <= expected_results.size();
  end

  initial begin
    logic [KeyW-1:0] k0, kf, kh, ka, k5, k6, k7;
    int unsigned     random_items;
    int unsigned     phase_kind;
    int unsigned     phase_len;
    int unsigned     r;
    int unsigned     ins_w, del_w, dec_w, fresh_pct;
    logic            steady;
    ftrc_req_t       op;

    k0 = '0;
    kf = '1;
    kh = 64'h8000_0000_0000_0000;
    ka = 64'hAAAA_AAAA_AAAA_AAAA;
    k5 = 64'h5555_5555_5555_5555;
    k6 = 64'h0123_4567_89AB_CDEF;
    k7 = {$urandom, $urandom};
    key_pool.push_back(k0);
    key_pool.push_back(kf);
    key_pool.push_back(kh);
    key_pool.push_back(ka);
    key_pool.push_back(k5);

    // Directed part, starting from the reset limit of three.
    push_request(REQ_INSERT, k0);
    push_request(REQ_INSERT, k0);       // already at the limit
    push_request(REQ_DECREMENT, k0);
    push_request(REQ_QUERY, k0);
    push_request(REQ_INSERT, k0);       // refresh climbs back to the limit
    push_request(REQ_INSERT, kf);
    push_request(REQ_QUERY, kf);
    push_request(REQ_DELETE, kf);
    push_request(REQ_DELETE, kf);       // absent key
    push_request(REQ_DECREMENT, kf);
    push_request(REQ_QUERY, kf);
    push_request(REQ_INSERT, kh);
    push_request(REQ_INSERT, ka);
    push_request(REQ_DECREMENT, k0);
    push_request(REQ_DECREMENT, k0);
    push_request(REQ_DECREMENT, k0);    // count of one: entry goes away
    push_control(STEP_DRAIN, '0);
    push_control(STEP_LIMIT, 8'd255);
    push_request(REQ_INSERT, k5);
    push_request(REQ_DECREMENT, k5);
    push_control(STEP_DRAIN, '0);
    push_control(STEP_LIMIT, 8'd0);
    push_request(REQ_INSERT, k6);       // stored with a zero count
    push_request(REQ_INSERT, k6);
    push_request(REQ_INSERT, k5);       // count above the new limit stays put
    push_request(REQ_DECREMENT, k6);
    push_control(STEP_DRAIN, '0);
    push_control(STEP_LIMIT, 8'd1);
    push_request(REQ_INSERT, k7);
    push_request(REQ_DECREMENT, k7);
    push_control(STEP_DRAIN, '0);

    // Random phases: churn on known keys, fill toward a full table, purge.
    random_items = 0;
    while (random_items < RandomItems) begin
      phase_kind = $urandom_range(0, 4);
      steady     = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(30, 70);
      case (phase_kind)
        3:       begin ins_w = 85; del_w = 5;  dec_w = 5;  fresh_pct = 60; end
        4:       begin ins_w = 10; del_w = 35; dec_w = 45; fresh_pct = 3;  end
        default: begin ins_w = 45; del_w = 15; dec_w = 30; fresh_pct = 10; end
      endcase
      for (int j = 0; j < phase_len; j++) begin
        r = $urandom_range(0, 99);
        if (r < ins_w) op = REQ_INSERT;
        else if (r < ins_w + del_w) op = REQ_DELETE;
        else if (r < ins_w + del_w + dec_w) op = REQ_DECREMENT;
        else op = REQ_QUERY;
        push_request(op, pick_key(fresh_pct, op == REQ_INSERT));
        if (steady) plan[plan.size() - 1].gap = '0;
        random_items++;
      end
      push_control(STEP_DRAIN, '0);
      if ($urandom_range(0, 9) < 6) push_control(STEP_LIMIT, pick_limit());
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (plan.size() != 0 || in_tvalid) @(posedge clk);
    while (n_outstanding != 0) @(posedge clk);
    repeat (2 * Entries + 4) @(posedge clk);

    $display("Checked %0d results: %0d hits, %0d removals, %0d table-full drops.",
             results_checked, hits_seen, removals_seen, drops_seen);
    $display("Table was full after %0d requests; refresh limit loaded %0d times.",
             full_seen, limit_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(20 * TimeoutCycles);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
